>>> hdl/breathing_temperature_colour_unit_assert.svh
// Assertion macros for the breathing temperature colour unit.
// Expects clk_i and rst_ni in the including module; no other dependencies.
`ifndef BREATHING_TEMPERATURE_COLOUR_UNIT_ASSERT_SVH
`define BREATHING_TEMPERATURE_COLOUR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on the rising edge of clk_i, switched off during reset.
`define BTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on the rising edge of clk_i at all times.
`define BTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define BTC_ASSERT(label, prop, msg)
`define BTC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> hdl/btc_pkg.sv
// Package for the breathing temperature colour unit: constants, the stage
// payload type and the constant-divisor helpers. No dependencies.
package btc_pkg;

  // Temperature bounds of the colour ramp in 1/16 degree units.
  localparam int TempLow  = 480;
  localparam int TempHigh = 608;

  // Reset values of the ceiling register and the breathing level.
  localparam logic [7:0] MaxLevelReset = 8'd200;
  localparam logic [7:0] LevelReset    = 8'd255;
  localparam logic [7:0] FloorReset    = 8'(MaxLevelReset / 12);

  // Payload held between the update stage and the colour stage.
  typedef struct packed {
    logic [7:0] level;   // updated breathing level
    logic [7:0] factor;  // ramp factor for the scaled channel
    logic       hot;     // step at or above the midpoint: green is scaled
  } btc_stage_t;

  // Floor of an 8-bit value divided by twelve, by multiplying by 171/2048.
  function automatic logic [7:0] div12(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return {3'b000, p[15:11]};
  endfunction

  // Floor of a product of two 8-bit values divided by 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> hdl/breathing_temperature_colour_unit.sv
// Top level of the breathing temperature colour unit.
// Depends on btc_pkg and on breathing_temperature_colour_unit_assert.svh.
//
// One tick beat in gives one colour beat out. The unit takes a new tick in
// every cycle while in_stall_o is low and delivers its colour through two
// register stages: the first updates the breathing level and maps the
// temperature to a ramp factor, the second scales the colour by the level
// through one 8x8 multiply and a divide by 255. The ceiling register may be
// written at any time the unit is idle; its write port is always ready.
`include "breathing_temperature_colour_unit_assert.svh"

module breathing_temperature_colour_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i,
  // Tick channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [11:0] temp_sixteenths_i,
  // Colour channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o
);
  import btc_pkg::*;

  logic       [7:0] max_level_q;
  logic       [7:0] floor_q;
  logic       [7:0] level_q, level_d;
  logic             falling_q, falling_d;
  logic             a_valid_q;
  btc_stage_t       a_q, a_d;
  logic             out_valid_q;
  logic       [7:0] red_q, red_d;
  logic       [7:0] green_q, green_d;
  logic             in_accept;
  logic             a_advance;
  logic             out_free;
  logic signed [12:0] t_ext;
  logic signed [12:0] t_off;
  logic       [15:0] ramp;
  logic       [7:0] step;
  logic       [8:0] hot_factor;
  logic       [15:0] product;
  logic       [7:0] scaled;

  // Configuration: the ceiling and its derived floor, written together.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MaxLevelReset;
      floor_q     <= FloorReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_level_q <= cfg_data_i;
      floor_q     <= div12(cfg_data_i);
    end
  end

  // Handshake: the output register frees when empty or taken, the update
  // stage moves on when the output register frees.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign a_advance  = a_valid_q && out_free;
  assign in_stall_o = a_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Breathing level: one step toward the current bound, clamping and
  // turning round when the bound is reached or passed.
  always_comb begin
    level_d   = level_q;
    falling_d = falling_q;
    if (falling_q) begin
      if (level_q <= floor_q) begin
        level_d   = floor_q;
        falling_d = 1'b0;
      end else begin
        level_d = level_q - 8'd1;
      end
    end else begin
      if (level_q >= max_level_q) begin
        level_d   = max_level_q;
        falling_d = 1'b1;
      end else begin
        level_d = level_q + 8'd1;
      end
    end
  end

  // Temperature to colour step: floor((t - 30 C) * 255 / 128), clamped.
  assign t_ext = 13'(temp_sixteenths_i);
  assign t_off = t_ext - 13'sd480;
  assign ramp  = {t_off[7:0], 8'b0} - {8'b0, t_off[7:0]};

  always_comb begin
    if (t_ext <= 13'(TempLow)) begin
      step = 8'd0;
    end else if (t_ext > 13'(TempHigh)) begin
      step = 8'd255;
    end else begin
      step = ramp[14:7];
    end
  end

  // Ramp factor: rising red below the midpoint, falling green above it.
  assign hot_factor = 9'd511 - {step, 1'b0};

  always_comb begin
    a_d.level = level_d;
    a_d.hot   = step[7];
    if (step[7]) begin
      a_d.factor = hot_factor[7:0];
    end else begin
      a_d.factor = {step[6:0], 1'b0};
    end
  end

  // Update stage registers; the level state moves once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= LevelReset;
      falling_q <= 1'b1;
      a_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        level_q   <= level_d;
        falling_q <= falling_d;
        a_valid_q <= 1'b1;
      end else if (a_advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= a_d;
    end
  end

  // Colour stage: scale one channel by level / 255, the other is the level.
  assign product = 16'(a_q.factor) * 16'(a_q.level);
  assign scaled  = div255(product);

  always_comb begin
    if (a_q.hot) begin
      red_d   = a_q.level;
      green_d = scaled;
    end else begin
      red_d   = scaled;
      green_d = a_q.level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_advance) begin
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;

  // The tick channel only stalls while the update stage holds a beat.
  `BTC_ASSERT(a_stall_needs_beat, in_stall_o |-> a_valid_q, "stall without a held beat")

  // A held beat waits unchanged while the colour beat is stalled.
  `BTC_ASSERT(a_hold_on_stall, in_stall_o |=> (a_valid_q && $stable(a_q)), "held beat changed")

  // A taken colour beat with nothing behind it leaves the output empty.
  `BTC_ASSERT(a_drain, (out_valid_o && out_free && !a_valid_q) |=> !out_valid_o, "beat repeated")

  // The floor never exceeds the ceiling.
  `BTC_ASSERT(a_floor_below_ceiling, floor_q <= max_level_q, "floor above ceiling")

endmodule

>>> test/breathing_temperature_colour_checker.sv
// Checker for the breathing temperature colour unit: watches the tick, colour and
// configuration channels, predicts every colour beat and compares it with the unit.
// Depends on btc_pkg for the temperature bounds and the reset values.
module breathing_temperature_colour_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               tick_valid_i,
  input  logic               tick_stall_i,
  input  logic signed [11:0] temp_sixteenths_i,
  input  logic               colour_valid_i,
  input  logic               colour_stall_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
  } colour_t;

  // Colours predicted for accepted ticks, oldest first.
  colour_t colours_due[$];

  // Own copy of the ceiling register and of the breathing state.
  logic [7:0] ceiling;
  logic [7:0] level;
  logic       falling;
  int         mismatches;

  // Maps a temperature to a ramp step and scales the ramp colour by the level.
  function automatic colour_t shade_colour(input logic [7:0] lvl,
                                           input logic signed [11:0] t);
    int      ti;
    int      step;
    int      l;
    colour_t c;
    ti = t;
    l  = lvl;
    if (ti <= btc_pkg::TempLow) begin
      step = 0;
    end else if (ti > btc_pkg::TempHigh) begin
      step = 255;
    end else begin
      step = ((ti - btc_pkg::TempLow) * 255) / 128;
    end
    if (step <= 127) begin
      c.red   = 8'((step * 2 * l) / 255);
      c.green = 8'(l);
    end else begin
      c.red   = 8'(l);
      c.green = 8'(((255 - (step - 128) * 2) * l) / 255);
    end
    return c;
  endfunction

  // Prediction on every accepted tick, comparison on every accepted colour beat.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] lvl_floor;
    colour_t    due;
    if (!rst_ni) begin
      ceiling    = btc_pkg::MaxLevelReset;
      level      = btc_pkg::LevelReset;
      falling    = 1'b1;
      mismatches = 0;
      colours_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (colour_valid_i && !colour_stall_i) begin
        if (colours_due.size() == 0) begin
          mismatches++;
          $display("%0t: colour beat with none due, red %0d green %0d",
                   $time, red_i, green_i);
        end else begin
          due = colours_due.pop_front();
          if (red_i !== due.red) begin
            mismatches++;
            $display("%0t: red expected %0d, got %0d", $time, due.red, red_i);
          end
          if (green_i !== due.green) begin
            mismatches++;
            $display("%0t: green expected %0d, got %0d", $time, due.green, green_i);
          end
        end
      end

      // The level takes one step towards its bound, or snaps to it and turns.
      if (tick_valid_i && !tick_stall_i) begin
        lvl_floor = ceiling / 8'd12;
        if (falling) begin
          if (level <= lvl_floor) begin
            level   = lvl_floor;
            falling = 1'b0;
          end else begin
            level = level - 8'd1;
          end
        end else begin
          if (level >= ceiling) begin
            level   = ceiling;
            falling = 1'b1;
          end else begin
            level = level + 8'd1;
          end
        end
        colours_due.push_back(shade_colour(level, temp_sixteenths_i));
      end

      if (cfg_valid_i && cfg_ready_i) begin
        ceiling = cfg_data_i;
      end

      fail_count_o <= mismatches;
      pending_o    <= colours_due.size();
    end
  end

endmodule

>>> test/tb_breathing_temperature_colour_unit.sv
// Testbench top for the breathing temperature colour unit: drives ticks, the
// ceiling register and colour back-pressure, and gives the verdict.
// Depends on breathing_temperature_colour_unit and breathing_temperature_colour_checker.
module tb_breathing_temperature_colour_unit;

  localparam int TickTotal      = 650;
  localparam int QuietTailStart = 560;
  localparam int WatchdogLimit  = 2000;
  localparam int DrainCycles    = 8;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = 8'd0;
  logic               tick_valid = 1'b0;
  logic               tick_stall;
  logic signed [11:0] temp = 12'sd0;
  logic               colour_valid;
  logic               colour_stall = 1'b0;
  logic [7:0]         red;
  logic [7:0]         green;
  int                 fail_count;
  int                 pending;
  int                 ticks_sent = 0;
  bit                 quiet_tail = 1'b0;
  int                 quiet_cycles = 0;

  breathing_temperature_colour_unit DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (tick_valid),
    .in_stall_o        (tick_stall),
    .temp_sixteenths_i (temp),
    .out_valid_o       (colour_valid),
    .out_stall_i       (colour_stall),
    .red_o             (red),
    .green_o           (green)
  );

  breathing_temperature_colour_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .tick_valid_i      (tick_valid),
    .tick_stall_i      (tick_stall),
    .temp_sixteenths_i (temp),
    .colour_valid_i    (colour_valid),
    .colour_stall_i    (colour_stall),
    .red_i             (red),
    .green_i           (green),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Ends the run if no beat of any kind is accepted for too long.
  always @(posedge clk) begin
    if ((tick_valid && !tick_stall) || (colour_valid && !colour_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_breathing_temperature_colour_unit: FAIL");
      $finish;
    end
  end

  // Colour back-pressure: random runs of stalls and free cycles.
  initial begin
    int run_len;
    bit hold;
    forever begin
      run_len = $urandom_range(1, 19);
      hold    = !quiet_tail && ($urandom_range(0, 2) == 0);
      repeat (run_len) begin
        @(posedge clk);
        colour_stall <= hold;
      end
    end
  end

  // Mostly temperatures around the ramp, with its edges and arbitrary patterns mixed in.
  function automatic logic signed [11:0] random_temp();
    case ($urandom_range(0, 7))
      0, 1: return 12'($urandom_range(0, 4095));
      2: begin
        case ($urandom_range(0, 5))
          0: return 12'sd480;
          1: return 12'sd481;
          2: return 12'sd544;
          3: return 12'sd545;
          4: return 12'sd608;
          default: return 12'sd609;
        endcase
      end
      default: return 12'($urandom_range(440, 650));
    endcase
  endfunction

  // Holds ticks back until every predicted colour has come out.
  task automatic wait_for_idle();
    tick_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_ceiling(input logic [7:0] value);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Sends one tick beat, sometimes after a gap, and waits for it to be taken.
  task automatic send_tick(input logic signed [11:0] t);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    temp       <= t;
    do @(posedge clk); while (tick_stall);
    ticks_sent++;
    if (ticks_sent >= QuietTailStart) quiet_tail = 1'b1;
  endtask

  initial begin
    int         phase_len;
    logic [7:0] ceiling_pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Temperature extremes and ramp edges under the reset ceiling.
    send_tick(-12'sd2048);
    send_tick(12'sd2047);
    send_tick(-12'sd1);
    send_tick(12'sd0);
    send_tick(12'sd480);
    send_tick(12'sd481);
    send_tick(12'sd544);
    send_tick(12'sd545);
    send_tick(12'sd608);
    send_tick(12'sd609);
    send_tick(12'h555);
    send_tick(12'haaa);

    // A few ticks under the highest and some low ceilings.
    write_ceiling(8'd255);
    repeat (4) send_tick(random_temp());
    write_ceiling(8'd1);
    repeat (3) send_tick(random_temp());
    write_ceiling(8'd12);
    repeat (3) send_tick(random_temp());

    // Zero ceiling: the level runs down to black and stays there.
    write_ceiling(8'd0);
    repeat (260) send_tick(random_temp());

    // From a level of zero, lowering the ceiling after a raise pulls a rising level down to
    // the ceiling, and raising it again lifts the falling level to the floor.
    write_ceiling(8'd255);
    send_tick(random_temp());
    write_ceiling(8'd0);
    send_tick(random_temp());
    write_ceiling(8'd255);
    send_tick(random_temp());

    // Random phases, each under a fresh ceiling.
    while (ticks_sent < TickTotal) begin
      case ($urandom_range(0, 5))
        0: ceiling_pick = 8'd0;
        1: ceiling_pick = 8'd255;
        2: ceiling_pick = 8'($urandom_range(1, 23));
        3: ceiling_pick = 8'($urandom_range(232, 254));
        default: ceiling_pick = 8'($urandom_range(0, 255));
      endcase
      write_ceiling(ceiling_pick);
      phase_len = $urandom_range(3, 60);
      repeat (phase_len) send_tick(random_temp());
    end

    wait_for_idle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_breathing_temperature_colour_unit: PASS");
    end else begin
      $display("tb_breathing_temperature_colour_unit: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/btc_pkg.sv
hdl/breathing_temperature_colour_unit.sv
test/breathing_temperature_colour_checker.sv
test/tb_breathing_temperature_colour_unit.sv
